// ----- rtl/core/optical_frame_receiver_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Optical frame receiver assertion macros
// Shared property forms for the receiver's checker, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef OPTICAL_FRAME_RECEIVER_UNIT_MACROS_SVH
`define OPTICAL_FRAME_RECEIVER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OFR_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ofr_pkg.sv -----
// ----------------------------------------------------------------------------
// Optical frame receiver package
// Receiver modes, register indexes, field widths and reset values.
// ----------------------------------------------------------------------------
package ofr_pkg;

  localparam int SAMPLE_W = 12;
  localparam int MARKER_W = 4;
  localparam int CFG_IDX_W = 2;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [MARKER_W-1:0] marker_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_WAIT = 2'd0,
    MODE_DATA = 2'd1,
    MODE_END  = 2'd2,
    MODE_FIN  = 2'd3
  } mode_t;

  localparam cfg_idx_t REG_THRESHOLD   = 2'd0;
  localparam cfg_idx_t REG_DATA_MARKER = 2'd1;
  localparam cfg_idx_t REG_END_MARKER  = 2'd2;

  localparam sample_t THRESHOLD_RST   = 12'd18;
  localparam marker_t DATA_MARKER_RST = 4'd8;
  localparam marker_t END_MARKER_RST  = 4'd4;
  localparam marker_t RUN_MAX         = 4'd15;

endpackage

// ----- rtl/core/optical_frame_receiver_unit.sv -----
// ----------------------------------------------------------------------------
// Optical frame receiver
// Slices light sensor samples against a threshold, detects data and end
// marker runs, captures frames and checks the end frame against the count.
// ----------------------------------------------------------------------------
// Usage: one sensor sample enters per beat on the in_ channel and exactly one
// result beat leaves on the out_ channel for every sample, in order. The
// sample is sliced, the receiver state is updated and the result is stored
// in the output register at the accepting edge, so a result appears in the cycle
// after its sample, with a throughput of one sample per cycle while out_ready is
// high; there is a single output register. in_ready stays high while the output
// register is empty or being emptied; when the receiver holds off out_ready,
// the pending result is kept and in_ready drops until it is taken.
// Registers are written over the cfg_ channel, which is always ready; writes
// to an index beyond the three registers are ignored. A synchronous reset
// restores register defaults, returns to waiting, clears the run, slot and
// frame counters and empties the output register. After the end frame the
// receiver stays finished until reset; samples are still sliced.
// ----------------------------------------------------------------------------
module optical_frame_receiver_unit #(
  parameter int FRAME_SLOTS = 12,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  ofr_pkg::sample_t       in_sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_light_bit,
  output logic [1:0]             out_mode,
  output logic                   out_frame_start,
  output logic                   out_frame_done,
  output logic                   out_end_done,
  output logic [FRAME_SLOTS-2:0] out_received_value,
  output logic [COUNT_WIDTH-1:0] out_frame_count,
  output logic                   out_count_match,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  ofr_pkg::cfg_idx_t      cfg_index,
  input  ofr_pkg::sample_t       cfg_data
);
  import ofr_pkg::*;

  localparam int VAL_W  = FRAME_SLOTS - 1;
  localparam int SLOT_W = $clog2(FRAME_SLOTS + 1);
  localparam int CMP_W  = (VAL_W > COUNT_WIDTH) ? VAL_W : COUNT_WIDTH;

  sample_t threshold_r;
  marker_t data_marker_r;
  marker_t end_marker_r;

  mode_t                   mode_r, mode_nxt;
  marker_t                 run_r, run_nxt;
  logic [SLOT_W-1:0]       slot_r, slot_nxt;
  logic [VAL_W-1:0]        cap_r, cap_nxt;
  logic [COUNT_WIDTH-1:0]  count_r, count_nxt;

  logic                    out_valid_r;
  logic                    light_bit_r;
  mode_t                   out_mode_r;
  logic                    start_r, done_r, end_done_r, match_r;
  logic [VAL_W-1:0]        value_r;
  logic [COUNT_WIDTH-1:0]  frame_count_r;

  logic                    accept;
  logic                    light;
  marker_t                 run_inc;
  logic                    start, done, end_done, match;
  logic                    last_slot;
  logic [VAL_W-1:0]        value;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;

  assign light     = in_sample > threshold_r;
  assign run_inc   = (run_r == RUN_MAX) ? RUN_MAX : run_r + 1'b1;
  assign last_slot = slot_r == SLOT_W'(FRAME_SLOTS);

  always_comb begin
    mode_nxt  = mode_r;
    run_nxt   = run_r;
    slot_nxt  = slot_r;
    cap_nxt   = cap_r;
    count_nxt = count_r;
    unique case (mode_r)
      MODE_WAIT: begin
        if (light) begin
          if (run_inc >= data_marker_r) begin
            run_nxt  = '0;
            mode_nxt = MODE_DATA;
            slot_nxt = SLOT_W'(1);
            if (count_r != {COUNT_WIDTH{1'b1}}) begin
              count_nxt = count_r + 1'b1;
            end
          end else begin
            run_nxt = run_inc;
          end
        end else begin
          run_nxt = '0;
          if (run_r >= end_marker_r && run_r < data_marker_r) begin
            mode_nxt = MODE_END;
            slot_nxt = SLOT_W'(1);
          end
        end
      end
      MODE_DATA, MODE_END: begin
        cap_nxt = VAL_W'({cap_r, light});
        if (last_slot) begin
          slot_nxt = '0;
          mode_nxt = (mode_r == MODE_DATA) ? MODE_WAIT : MODE_FIN;
        end else begin
          slot_nxt = slot_r + 1'b1;
        end
      end
      MODE_FIN: begin
        mode_nxt = MODE_FIN;
      end
      default: begin
        mode_nxt = MODE_WAIT;
      end
    endcase
  end

  always_comb begin
    start    = 1'b0;
    done     = 1'b0;
    end_done = 1'b0;
    value    = '0;
    match    = 1'b0;
    unique case (mode_r)
      MODE_WAIT: begin
        start = (mode_nxt != MODE_WAIT);
      end
      MODE_DATA: begin
        done  = last_slot;
        value = last_slot ? cap_nxt : '0;
      end
      MODE_END: begin
        end_done = last_slot;
        value    = last_slot ? cap_nxt : '0;
        match    = last_slot && (CMP_W'(cap_nxt) == CMP_W'(count_r));
      end
      MODE_FIN: begin
        start = 1'b0;
      end
      default: begin
        start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r   <= THRESHOLD_RST;
      data_marker_r <= DATA_MARKER_RST;
      end_marker_r  <= END_MARKER_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_THRESHOLD:   threshold_r   <= cfg_data;
        REG_DATA_MARKER: data_marker_r <= cfg_data[MARKER_W-1:0];
        REG_END_MARKER:  end_marker_r  <= cfg_data[MARKER_W-1:0];
        default: begin
          threshold_r <= threshold_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_WAIT;
      run_r       <= '0;
      slot_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        mode_r      <= mode_nxt;
        run_r       <= run_nxt;
        slot_r      <= slot_nxt;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cap_r         <= cap_nxt;
      light_bit_r   <= light;
      out_mode_r    <= mode_nxt;
      start_r       <= start;
      done_r        <= done;
      end_done_r    <= end_done;
      value_r       <= value;
      frame_count_r <= count_nxt;
      match_r       <= match;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_light_bit      = light_bit_r;
  assign out_mode           = out_mode_r;
  assign out_frame_start    = start_r;
  assign out_frame_done     = done_r;
  assign out_end_done       = end_done_r;
  assign out_received_value = value_r;
  assign out_frame_count    = frame_count_r;
  assign out_count_match    = match_r;

endmodule

// ----- rtl/core/ofr_checker.sv -----
// ----------------------------------------------------------------------------
// Optical frame receiver checker
// Port-level properties of the receiver, attached to the receiver module by bind.
// ----------------------------------------------------------------------------
`include "optical_frame_receiver_unit_macros.svh"

module ofr_checker #(
  parameter int FRAME_SLOTS = 12,
  parameter int COUNT_WIDTH = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input ofr_pkg::sample_t       in_sample,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   out_light_bit,
  input logic [1:0]             out_mode,
  input logic                   out_frame_start,
  input logic                   out_frame_done,
  input logic                   out_end_done,
  input logic [FRAME_SLOTS-2:0] out_received_value,
  input logic [COUNT_WIDTH-1:0] out_frame_count,
  input logic                   out_count_match,
  input logic                   cfg_valid,
  input logic                   cfg_ready,
  input ofr_pkg::cfg_idx_t      cfg_index,
  input ofr_pkg::sample_t       cfg_data
);
  import ofr_pkg::*;

  `OFR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_mode) && $stable(out_received_value) &&
    $stable(out_frame_count) && $stable(out_light_bit),
    "Stalled result beat changed")

  `OFR_ASSERT_IMPLY(a_one_event, out_valid,
    $onehot0({out_frame_start, out_frame_done, out_end_done}),
    "More than one frame event in one beat")

  `OFR_ASSERT_IMPLY(a_end_mode, out_valid && out_end_done,
    out_mode == MODE_FIN,
    "End frame completed without entering the finished mode")

  `OFR_ASSERT_IMPLY(a_value_idle, out_valid && !out_frame_done && !out_end_done,
    out_received_value == '0 && !out_count_match,
    "Value or match reported without a completed frame")

endmodule

bind optical_frame_receiver_unit ofr_checker #(
  .FRAME_SLOTS(FRAME_SLOTS),
  .COUNT_WIDTH(COUNT_WIDTH)
) u_ofr_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .in_sample          (in_sample),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_light_bit      (out_light_bit),
  .out_mode           (out_mode),
  .out_frame_start    (out_frame_start),
  .out_frame_done     (out_frame_done),
  .out_end_done       (out_end_done),
  .out_received_value (out_received_value),
  .out_frame_count    (out_frame_count),
  .out_count_match    (out_count_match),
  .cfg_valid          (cfg_valid),
  .cfg_ready          (cfg_ready),
  .cfg_index          (cfg_index),
  .cfg_data           (cfg_data)
);

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// Optical frame receiver testbench
// Feeds light sensor samples through the receiver with random gaps on both
// channels and checks every result beat against a cycle-free model of the
// receiver: slicing, marker runs, data frames, the end frame and its count
// match, and the finished state. Registers are reprogrammed between phases
// while no beat is in flight.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ofr_pkg::*;

  localparam int FRAME_SLOTS = 12;
  localparam int COUNT_WIDTH = 16;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int STALL_PCT = 35;
  localparam cfg_idx_t REG_UNUSED = 2'd3;

  typedef struct packed {
    logic                   light_bit;
    mode_t                  mode;
    logic                   frame_start;
    logic                   frame_done;
    logic                   end_done;
    logic [FRAME_SLOTS-2:0] received_value;
    logic [COUNT_WIDTH-1:0] frame_count;
    logic                   count_match;
  } rx_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  sample_t in_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_light_bit;
  logic [1:0] out_mode;
  logic out_frame_start;
  logic out_frame_done;
  logic out_end_done;
  logic [FRAME_SLOTS-2:0] out_received_value;
  logic [COUNT_WIDTH-1:0] out_frame_count;
  logic out_count_match;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_idx_t cfg_index = '0;
  sample_t cfg_data = '0;

  // Receiver model state and its copy of the registers.
  sample_t thr_cfg = THRESHOLD_RST;
  marker_t data_len_cfg = DATA_MARKER_RST;
  marker_t end_len_cfg = END_MARKER_RST;
  mode_t pr_mode = MODE_WAIT;
  marker_t pr_run = '0;
  int pr_slot = 0;
  logic [FRAME_SLOTS-1:0] pr_shift = '0;
  logic [COUNT_WIDTH-1:0] pr_frames = '0;

  sample_t pending_samples[$];
  rx_result_t awaited_results[$];
  rx_result_t head_result;
  bit no_gaps = 1'b0;
  int cycle_count = 0;
  int mismatches = 0;
  int queued_total = 0;
  int samples_sent = 0;
  int results_checked = 0;
  int data_frames_seen = 0;
  int end_frames_seen = 0;

  sample_t opening_seq [25] = '{18, 19, 4095, 20, 0,
                                19, 4095, 100, 200, 300, 400, 500, 600,
                                0, 4095, 18, 19, 0, 3000, 7, 2222, 9, 1234, 18, 4000};

  optical_frame_receiver_unit #(
    .FRAME_SLOTS(FRAME_SLOTS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_sample(in_sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_light_bit(out_light_bit),
    .out_mode(out_mode),
    .out_frame_start(out_frame_start),
    .out_frame_done(out_frame_done),
    .out_end_done(out_end_done),
    .out_received_value(out_received_value),
    .out_frame_count(out_frame_count),
    .out_count_match(out_count_match),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic rx_result_t receive_sample(sample_t smp);
    rx_result_t res;
    logic [FRAME_SLOTS-2:0] value;
    res = '0;
    value = '0;
    res.light_bit = (smp > thr_cfg);
    case (pr_mode)
      MODE_WAIT: begin
        if (res.light_bit) begin
          if (pr_run < RUN_MAX) pr_run = pr_run + 1'b1;
          if (pr_run >= data_len_cfg) begin
            pr_run = '0;
            pr_mode = MODE_DATA;
            if (pr_frames != '1) pr_frames = pr_frames + 1'b1;
            res.frame_start = 1'b1;
          end
        end else begin
          if (pr_run >= end_len_cfg && pr_run < data_len_cfg) begin
            pr_mode = MODE_END;
            res.frame_start = 1'b1;
          end
          pr_run = '0;
        end
        if (res.frame_start) begin
          pr_shift = '0;
          pr_slot = 1;
        end
      end
      MODE_DATA, MODE_END: begin
        pr_shift = {pr_shift[FRAME_SLOTS-2:0], res.light_bit};
        pr_slot++;
        if (pr_slot >= FRAME_SLOTS + 1) begin
          value = pr_shift[FRAME_SLOTS-2:0];
          pr_slot = 0;
          if (pr_mode == MODE_DATA) begin
            pr_mode = MODE_WAIT;
            res.frame_done = 1'b1;
          end else begin
            pr_mode = MODE_FIN;
            res.end_done = 1'b1;
            res.count_match = (COUNT_WIDTH'(value) == pr_frames);
          end
        end
      end
      default: ;
    endcase
    res.mode = pr_mode;
    res.received_value = value;
    res.frame_count = pr_frames;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("tb_top: %s mismatch at result %0d: got 'h%0h, want 'h%0h",
             what, results_checked, got, want);
    mismatches++;
  endtask

  // Sample driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_sample <= '0;
    end else begin
      if (in_valid && in_ready) begin
        awaited_results.push_back(receive_sample(in_sample));
        samples_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_samples.size() != 0 && (no_gaps || $urandom_range(99) >= STALL_PCT)) begin
          in_valid <= 1'b1;
          in_sample <= pending_samples.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unrequested result", 32'd1, 32'd0);
        end else begin
          head_result = awaited_results.pop_front();
          if (out_light_bit !== head_result.light_bit)
            report_mismatch("light_bit", out_light_bit, head_result.light_bit);
          if (out_mode !== head_result.mode)
            report_mismatch("mode", out_mode, head_result.mode);
          if (out_frame_start !== head_result.frame_start)
            report_mismatch("frame_start", out_frame_start, head_result.frame_start);
          if (out_frame_done !== head_result.frame_done)
            report_mismatch("frame_done", out_frame_done, head_result.frame_done);
          if (out_end_done !== head_result.end_done)
            report_mismatch("end_done", out_end_done, head_result.end_done);
          if (out_received_value !== head_result.received_value)
            report_mismatch("received_value", out_received_value, head_result.received_value);
          if (out_frame_count !== head_result.frame_count)
            report_mismatch("frame_count", out_frame_count, head_result.frame_count);
          if (out_count_match !== head_result.count_match)
            report_mismatch("count_match", out_count_match, head_result.count_match);
          if (head_result.frame_done) data_frames_seen++;
          if (head_result.end_done) end_frames_seen++;
        end
        results_checked++;
      end
      out_ready <= no_gaps || ($urandom_range(99) >= STALL_PCT);
    end
  end

  function automatic sample_t lit();
    if (thr_cfg == 12'hFFF) return 12'hFFF;
    return sample_t'($urandom_range(4095, int'(thr_cfg) + 1));
  endfunction

  function automatic sample_t unlit();
    return sample_t'($urandom_range(int'(thr_cfg), 0));
  endfunction

  task automatic push_sample(sample_t smp);
    pending_samples.push_back(smp);
    queued_total++;
  endtask

  task automatic queue_frame(int gap, logic [FRAME_SLOTS-1:0] bits);
    repeat (gap) push_sample(unlit());
    repeat ((data_len_cfg == 0) ? 1 : int'(data_len_cfg)) push_sample(lit());
    for (int i = FRAME_SLOTS - 1; i >= 0; i--) push_sample(bits[i] ? lit() : unlit());
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_samples.size() != 0 || in_valid || awaited_results.size() != 0);
  endtask

  task automatic write_beat(cfg_idx_t idx, sample_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      REG_THRESHOLD:   thr_cfg = data;
      REG_DATA_MARKER: data_len_cfg = data[MARKER_W-1:0];
      REG_END_MARKER:  end_len_cfg = data[MARKER_W-1:0];
      default: ;
    endcase
  endtask

  // Marker writes carry random upper bits, which the block must drop.
  task automatic program_regs(sample_t thr, marker_t dlen, marker_t elen);
    write_beat(REG_UNUSED, sample_t'($urandom));
    write_beat(REG_THRESHOLD, thr);
    write_beat(REG_DATA_MARKER, {8'($urandom), dlen});
    write_beat(REG_END_MARKER, {8'($urandom), elen});
    cfg_valid <= 1'b0;
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    int phase;
    int next_cfg_at;
    int roll;
    int t;
    int d;
    int e;
    int r;
    phase = 0;
    next_cfg_at = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_seq[k]) push_sample(opening_seq[k]);

    // End markers stay at or above the data marker here, so no end frame can start.
    while (queued_total < 1400) begin
      if (queued_total >= next_cfg_at) begin
        wait_idle();
        case (phase)
          0: begin t = 0; d = $urandom_range(15, 1); end
          1: begin t = 4095; d = 8; end
          2: begin t = $urandom_range(4095); d = 0; end
          3: begin t = $urandom_range(300); d = 15; end
          default: begin
            t = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(400);
            d = $urandom_range(15);
          end
        endcase
        e = $urandom_range(15, d);
        program_regs(sample_t'(t), marker_t'(d), marker_t'(e));
        no_gaps = (phase == 5);
        phase++;
        next_cfg_at = queued_total + 120;
      end
      roll = $urandom_range(99);
      if (roll < 75) begin
        queue_frame($urandom_range(2), FRAME_SLOTS'($urandom));
      end else if (roll < 90) begin
        r = (data_len_cfg == 0) ? 0 : $urandom_range(int'(data_len_cfg) - 1);
        repeat (r) push_sample(lit());
        push_sample(unlit());
      end else begin
        repeat ($urandom_range(6, 1)) push_sample(sample_t'($urandom));
      end
    end
    no_gaps = 1'b0;
    repeat (FRAME_SLOTS + 1) push_sample(unlit());
    wait_idle();

    d = $urandom_range(15, 1);
    r = $urandom_range(d - 1, 0);
    program_regs(sample_t'($urandom_range(4000, 100)), marker_t'(d), 4'd0);
    repeat (r) push_sample(lit());
    push_sample(unlit());
    push_sample(($urandom_range(1) != 0) ? lit() : unlit());
    for (int i = FRAME_SLOTS - 2; i >= 0; i--) push_sample(pr_frames[i] ? lit() : unlit());
    wait_idle();

    program_regs(sample_t'($urandom), marker_t'($urandom_range(15)), marker_t'($urandom_range(15)));
    repeat (40) push_sample(($urandom_range(1) != 0) ? sample_t'($urandom) : lit());
    wait_idle();
    repeat (5) @(posedge clk);

    $display("tb_top: %0d samples sent, %0d results compared, %0d data frames, %0d end frame",
             samples_sent, results_checked, data_frames_seen, end_frames_seen);
    $display("tb_top: end frame carried the frame count %0d, then samples ran in finished mode",
             pr_frames);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/ofr_pkg.sv
rtl/core/optical_frame_receiver_unit.sv
rtl/core/ofr_checker.sv
sim/tb_top.sv
